// ----- src/fmbq_pkg.sv -----
// Shared constants, codes and types for the front/middle/back queue.
`default_nettype none

package fmbq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int VALUE_W      = 32;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_MID    = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0]  popped_value;
    logic [STATUS_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic value;
    logic front;
    logic back;
  } node_we_t;

endpackage

`default_nettype wire

// ----- src/front_middle_back_queue_top.sv -----
// Top level: front/middle/back queue with sequencer, node and free-stack memories, output register.
// Push: node read, then node write and neighbour link write (no link write when empty); no result word.
// Pop: node read, unlink with the result posted, then link fix; the result passes the output register.
// Rejected push, pop on empty: result posted on accept, no node access; unused kind: no result, no effect.
// Rate is set by the single node-memory port: a node read, then up to two node writes.
// Synchronous reset empties the queue at once; the free stack uses a low mark, no clearing pass.
`default_nettype none

module front_middle_back_queue_top
  import fmbq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic        [KIND_W-1:0]   kind,
  input  wire logic signed [VALUE_W-1:0]  value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed      [VALUE_W-1:0]  popped_value,
  output logic             [STATUS_W-1:0] status
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY+1);

  logic                res_valid;
  res_t                res;
  logic                res_take;

  logic                node_re;
  node_we_t            node_we;
  logic [SLOT_W-1:0]   node_addr;
  logic [VALUE_W-1:0]  node_wr_value;
  logic [LINK_W-1:0]   node_wr_front;
  logic [LINK_W-1:0]   node_wr_back;
  logic [VALUE_W-1:0]  node_rd_value;
  logic [LINK_W-1:0]   node_rd_front;
  logic [LINK_W-1:0]   node_rd_back;

  logic                free_we;
  logic [SLOT_W-1:0]   free_waddr;
  logic [SLOT_W-1:0]   free_wdata;
  logic                free_re;
  logic [SLOT_W-1:0]   free_raddr;
  logic [SLOT_W-1:0]   free_rdata;

  fmbq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .value         (value),
    .res_valid     (res_valid),
    .res           (res),
    .res_take      (res_take),
    .node_re       (node_re),
    .node_we       (node_we),
    .node_addr     (node_addr),
    .node_wr_value (node_wr_value),
    .node_wr_front (node_wr_front),
    .node_wr_back  (node_wr_back),
    .node_rd_value (node_rd_value),
    .node_rd_front (node_rd_front),
    .node_rd_back  (node_rd_back),
    .free_we       (free_we),
    .free_waddr    (free_waddr),
    .free_wdata    (free_wdata),
    .free_re       (free_re),
    .free_raddr    (free_raddr),
    .free_rdata    (free_rdata)
  );

  fmbq_node_mem #(.CAPACITY(CAPACITY)) u_node_mem (
    .clk      (clk),
    .re       (node_re),
    .we       (node_we),
    .addr     (node_addr),
    .wr_value (node_wr_value),
    .wr_front (node_wr_front),
    .wr_back  (node_wr_back),
    .rd_value (node_rd_value),
    .rd_front (node_rd_front),
    .rd_back  (node_rd_back)
  );

  fmbq_free_mem #(.CAPACITY(CAPACITY)) u_free_mem (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .re    (free_re),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      popped_value <= res.popped_value;
      status       <= res.status;
    end
  end

endmodule

`default_nettype wire

// ----- src/fmbq_node_mem.sv -----
// Node store: value and both links per slot, one shared address, registered read.
`default_nettype none

module fmbq_node_mem
  import fmbq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              re,
  input  wire node_we_t                          we,
  input  wire logic [$clog2(CAPACITY)-1:0]       addr,
  input  wire logic [VALUE_W-1:0]                wr_value,
  input  wire logic [$clog2(CAPACITY+1)-1:0]     wr_front,
  input  wire logic [$clog2(CAPACITY+1)-1:0]     wr_back,
  output logic      [VALUE_W-1:0]                rd_value,
  output logic      [$clog2(CAPACITY+1)-1:0]     rd_front,
  output logic      [$clog2(CAPACITY+1)-1:0]     rd_back
);

  localparam int LINK_W = $clog2(CAPACITY+1);

  logic [VALUE_W-1:0] value_mem [CAPACITY];
  logic [LINK_W-1:0]  front_mem [CAPACITY];
  logic [LINK_W-1:0]  back_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (we.value) begin
      value_mem[addr] <= wr_value;
    end
    if (we.front) begin
      front_mem[addr] <= wr_front;
    end
    if (we.back) begin
      back_mem[addr] <= wr_back;
    end
    if (re) begin
      rd_value <= value_mem[addr];
      rd_front <= front_mem[addr];
      rd_back  <= back_mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/fmbq_free_mem.sv -----
// Free slot stack storage: one write and one registered read per cycle.
`default_nettype none

module fmbq_free_mem
  import fmbq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [$clog2(CAPACITY)-1:0] waddr,
  input  wire logic [$clog2(CAPACITY)-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [$clog2(CAPACITY)-1:0] raddr,
  output logic      [$clog2(CAPACITY)-1:0] rdata
);

  localparam int SLOT_W = $clog2(CAPACITY);

  logic [SLOT_W-1:0] stack_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= stack_mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/fmbq_ctrl.sv -----
// Sequencer: list pointers, free stack top, node read-modify-write and result hold.
`default_nettype none

module fmbq_ctrl
  import fmbq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [KIND_W-1:0]                 kind,
  input  wire logic [VALUE_W-1:0]                value,
  output logic                                   res_valid,
  output res_t                                   res,
  input  wire logic                              res_take,
  output logic                                   node_re,
  output node_we_t                               node_we,
  output logic      [$clog2(CAPACITY)-1:0]       node_addr,
  output logic      [VALUE_W-1:0]                node_wr_value,
  output logic      [$clog2(CAPACITY+1)-1:0]     node_wr_front,
  output logic      [$clog2(CAPACITY+1)-1:0]     node_wr_back,
  input  wire logic [VALUE_W-1:0]                node_rd_value,
  input  wire logic [$clog2(CAPACITY+1)-1:0]     node_rd_front,
  input  wire logic [$clog2(CAPACITY+1)-1:0]     node_rd_back,
  output logic                                   free_we,
  output logic      [$clog2(CAPACITY)-1:0]       free_waddr,
  output logic      [$clog2(CAPACITY)-1:0]       free_wdata,
  output logic                                   free_re,
  output logic      [$clog2(CAPACITY)-1:0]       free_raddr,
  input  wire logic [$clog2(CAPACITY)-1:0]       free_rdata
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY+1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_NODE,
    S_PUSH_LINK,
    S_POP_UNLINK,
    S_POP_FIX
  } state_t;

  state_t              state;
  logic [LINK_W-1:0]   head;
  logic [LINK_W-1:0]   tail;
  logic [LINK_W-1:0]   middle;
  logic [LINK_W-1:0]   count;
  logic [LINK_W-1:0]   top;
  logic [LINK_W-1:0]   low;
  logic [KIND_W-1:0]   kind_r;
  logic [VALUE_W-1:0]  value_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                from_mem;
  logic [LINK_W-1:0]   link_f;
  logic [LINK_W-1:0]   link_b;

  logic                accept;
  logic                is_push;
  logic                fresh;
  logic [LINK_W-1:0]   top_dec;
  logic [LINK_W-1:0]   fresh_link;
  logic [SLOT_W-1:0]   new_slot;
  logic [LINK_W-1:0]   new_link;

  // Entries below the low mark of the stack were never written and hold no
  // valid slot number, so the slot is computed instead of read.
  assign in_stall   = (state != S_IDLE) || res_valid;
  assign accept     = in_valid && !in_stall;
  assign is_push    = (kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK);
  assign fresh      = (top == low);
  assign top_dec    = top - 1'b1;
  assign fresh_link = NULL_LINK - top;
  assign new_slot   = from_mem ? free_rdata : slot_r;
  assign new_link   = LINK_W'(new_slot);

  always_comb begin
    node_re       = 1'b0;
    node_we       = '0;
    node_addr     = middle[SLOT_W-1:0];
    node_wr_value = value_r;
    node_wr_front = NULL_LINK;
    node_wr_back  = NULL_LINK;
    free_we       = 1'b0;
    free_waddr    = top[SLOT_W-1:0];
    free_wdata    = middle[SLOT_W-1:0];
    free_re       = 1'b0;
    free_raddr    = top_dec[SLOT_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept && is_push && count != NULL_LINK) begin
          node_re = 1'b1;
          free_re = !fresh;
        end else if (accept && kind == KIND_POP_MID && count != '0) begin
          node_re = 1'b1;
        end
      end
      S_PUSH_NODE: begin
        node_we   = '{value: 1'b1, front: 1'b1, back: 1'b1};
        node_addr = new_slot;
        if (count != '0) begin
          if (kind_r == KIND_PUSH_FRONT) begin
            node_wr_back = head;
          end else begin
            node_wr_front = tail;
          end
        end
      end
      S_PUSH_LINK: begin
        if (kind_r == KIND_PUSH_FRONT) begin
          node_we.front = 1'b1;
          node_addr     = head[SLOT_W-1:0];
          node_wr_front = LINK_W'(slot_r);
        end else begin
          node_we.back = 1'b1;
          node_addr    = tail[SLOT_W-1:0];
          node_wr_back = LINK_W'(slot_r);
        end
      end
      S_POP_UNLINK: begin
        free_we      = 1'b1;
        node_we.back = (node_rd_front != NULL_LINK);
        node_addr    = node_rd_front[SLOT_W-1:0];
        node_wr_back = node_rd_back;
      end
      S_POP_FIX: begin
        node_we.front = (link_b != NULL_LINK);
        node_addr     = link_b[SLOT_W-1:0];
        node_wr_front = link_f;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NULL_LINK;
      tail      <= NULL_LINK;
      middle    <= NULL_LINK;
      count     <= '0;
      top       <= NULL_LINK;
      low       <= NULL_LINK;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_take) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r  <= kind;
            value_r <= value;
            case (kind)
              KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (count == NULL_LINK) begin
                  res_valid <= 1'b1;
                  res       <= '{popped_value: '0, status: STAT_FULL};
                end else begin
                  top      <= top_dec;
                  from_mem <= !fresh;
                  slot_r   <= fresh_link[SLOT_W-1:0];
                  if (fresh) begin
                    low <= low - 1'b1;
                  end
                  state <= S_PUSH_NODE;
                end
              end
              KIND_POP_MID: begin
                if (count == '0) begin
                  res_valid <= 1'b1;
                  res       <= '{popped_value: '0, status: STAT_EMPTY};
                end else begin
                  state <= S_POP_UNLINK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PUSH_NODE: begin
          slot_r <= new_slot;
          count  <= count + 1'b1;
          if (count == '0) begin
            head   <= new_link;
            tail   <= new_link;
            middle <= new_link;
            state  <= S_IDLE;
          end else begin
            if (kind_r == KIND_PUSH_FRONT) begin
              if (count[0]) begin
                middle <= (count == LINK_W'(1)) ? new_link : node_rd_front;
              end
            end else if (!count[0]) begin
              middle <= node_rd_back;
            end
            state <= S_PUSH_LINK;
          end
        end
        S_PUSH_LINK: begin
          if (kind_r == KIND_PUSH_FRONT) begin
            head <= LINK_W'(slot_r);
          end else begin
            tail <= LINK_W'(slot_r);
          end
          state <= S_IDLE;
        end
        S_POP_UNLINK: begin
          link_f <= node_rd_front;
          link_b <= node_rd_back;
          if (node_rd_front == NULL_LINK) begin
            head <= node_rd_back;
          end
          if (node_rd_back == NULL_LINK) begin
            tail <= node_rd_front;
          end
          middle    <= count[0] ? node_rd_front : node_rd_back;
          top       <= top + 1'b1;
          count     <= count - 1'b1;
          res_valid <= 1'b1;
          res       <= '{popped_value: node_rd_value, status: STAT_OK};
          state     <= S_POP_FIX;
        end
        S_POP_FIX: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_slots_conserved: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |->
      (({1'b0, top} + {1'b0, count}) == (LINK_W+1)'(CAPACITY)))
    else $error("free plus used slots differ from capacity");

  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    low <= top)
    else $error("free stack low mark above top");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count == '0) |->
      (head == NULL_LINK && tail == NULL_LINK && middle == NULL_LINK))
    else $error("empty queue with live pointers");

  a_live_ptrs: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count != '0) |->
      (head != NULL_LINK && tail != NULL_LINK && middle != NULL_LINK))
    else $error("nonempty queue with null pointer");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_UNLINK) |=> (res_valid && res.status == STAT_OK))
    else $error("pop did not post a result");

endmodule

`default_nettype wire
